>>> design/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared constants and types for the SLIP frame decoder
// Framing byte codes, field widths and the result control group.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgWidth  = 12;

  localparam logic [ByteWidth-1:0] SlipEnd    = 8'hC0;
  localparam logic [ByteWidth-1:0] SlipEsc    = 8'hDB;
  localparam logic [ByteWidth-1:0] SlipEscEnd = 8'hDC;
  localparam logic [ByteWidth-1:0] SlipEscEsc = 8'hDD;

  // control bits of one decoded result
  typedef struct packed {
    logic valid;  // accepted byte produced a result
    logic last;   // result is a frame close
  } sfd_res_ctrl_t;

endpackage

>>> design/slip_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_decoder: SLIP framing removal on a received byte stream
// Strips END/ESC framing and reports per-frame data length.
// ----------------------------------------------------------------------------
// Usage:
//   Raw serial bytes arrive on the s_axis channel, one byte per beat.
//   Each data byte inside a frame leaves on m_axis with tlast low and the
//   running kept-byte count; a closing END leaves one beat with tlast high,
//   out_byte zero and the final frame length. Escapes and bytes outside a
//   frame, and data bytes past max_length, produce no output beat.
//   max_length is written through cfg_we_i / cfg_wdata_i while idle.
// Data path and throughput:
//   Each accepted beat is decoded in a single combinational step into the
//   output register, or into the skid register while m_axis is stalled.
//   One byte per cycle sustained while m_axis is not stalled.
// Reset:
//   Decoder hunts for an opening END, count is zero, max_length is all ones,
//   output and skid registers are empty.
// Stall:
//   A one-entry skid register behind the output register lets one more beat
//   in while m_axis is stalled; s_axis_tready_o drops once the skid fills.
// ----------------------------------------------------------------------------
module slip_frame_decoder #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_byte, [LENGTH_BITS+7:8] frame_length, zero pad above
  output logic [((8+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o,   // frame_end
  input  logic                          cfg_we_i,
  input  logic [sfd_pkg::CfgWidth-1:0]  cfg_wdata_i       // max_length
);
  import sfd_pkg::*;

  localparam int unsigned PayWidth  = ByteWidth + LENGTH_BITS;
  localparam int unsigned DataWidth = ((PayWidth + 7) / 8) * 8;

  logic                   acc;
  logic                   pop;
  sfd_res_ctrl_t          res_ctrl;
  logic [ByteWidth-1:0]   res_byte;
  logic [LENGTH_BITS-1:0] res_len;
  logic [PayWidth-1:0]    res_pay;

  logic                   out_vld_q, skid_vld_q;
  logic                   out_last_q, skid_last_q;
  logic [PayWidth-1:0]    out_pay_q, skid_pay_q;

  assign s_axis_tready_o = !skid_vld_q;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_vld_q && m_axis_tready_i;
  assign res_pay         = {res_len, res_byte};

  sfd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_o      (res_ctrl),
    .byte_o      (res_byte),
    .len_o       (res_len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (acc && res_ctrl.valid) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_pay_q  <= skid_pay_q;
        out_last_q <= skid_last_q;
      end
    end else if (acc && res_ctrl.valid) begin
      if (!out_vld_q || pop) begin
        out_pay_q  <= res_pay;
        out_last_q <= res_ctrl.last;
      end else begin
        skid_pay_q  <= res_pay;
        skid_last_q <= res_ctrl.last;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = DataWidth'(out_pay_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> design/sfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core: SLIP decode state and per-byte result logic
// Holds the decode mode, the kept byte count and the max_length register.
// ----------------------------------------------------------------------------
module sfd_core #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           acc_i,
  input  logic [sfd_pkg::ByteWidth-1:0]  byte_i,
  input  logic                           cfg_we_i,
  input  logic [sfd_pkg::CfgWidth-1:0]   cfg_wdata_i,
  output sfd_pkg::sfd_res_ctrl_t         ctrl_o,
  output logic [sfd_pkg::ByteWidth-1:0]  byte_o,
  output logic [LENGTH_BITS-1:0]         len_o
);
  import sfd_pkg::*;

  localparam logic [1:0] ModeHunt    = 2'd0;
  localparam logic [1:0] ModeFrame   = 2'd1;
  localparam logic [1:0] ModeEscaped = 2'd2;

  localparam int unsigned ExtWidth = (LENGTH_BITS > CfgWidth) ? LENGTH_BITS : CfgWidth;

  logic [1:0]             mode_q, mode_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [LENGTH_BITS-1:0] max_len_q, max_len_d;
  logic [ExtWidth-1:0]    cfg_ext;
  logic [ByteWidth-1:0]   data_byte;
  logic                   room;

  assign cfg_ext   = ExtWidth'(cfg_wdata_i);
  assign max_len_d = cfg_ext[LENGTH_BITS-1:0];
  assign room      = (count_q < max_len_q);

  always_comb begin
    data_byte = byte_i;
    if (mode_q == ModeEscaped) begin
      if (byte_i == SlipEscEnd) begin
        data_byte = SlipEnd;
      end else if (byte_i == SlipEscEsc) begin
        data_byte = SlipEsc;
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    count_d      = count_q;
    ctrl_o.valid = 1'b0;
    ctrl_o.last  = 1'b0;
    byte_o       = data_byte;
    len_o        = count_q + LENGTH_BITS'(1);
    case (mode_q)
      ModeFrame: begin
        if (byte_i == SlipEnd) begin
          ctrl_o.valid = 1'b1;
          ctrl_o.last  = 1'b1;
          byte_o       = '0;
          len_o        = count_q;
          mode_d       = ModeHunt;
          count_d      = '0;
        end else if (byte_i == SlipEsc) begin
          mode_d = ModeEscaped;
        end else if (room) begin
          ctrl_o.valid = 1'b1;
          count_d      = count_q + LENGTH_BITS'(1);
        end
      end
      ModeEscaped: begin
        // any byte after an escape is data, END included
        mode_d = ModeFrame;
        if (room) begin
          ctrl_o.valid = 1'b1;
          count_d      = count_q + LENGTH_BITS'(1);
        end
      end
      default: begin
        if (byte_i == SlipEnd) begin
          mode_d  = ModeFrame;
          count_d = '0;
        end else begin
          mode_d = ModeHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeHunt;
      count_q   <= '0;
      max_len_q <= '1;
    end else begin
      if (acc_i) begin
        mode_q  <= mode_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        max_len_q <= max_len_d;
      end
    end
  end

endmodule

>>> design/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: port-level assertions for the SLIP frame decoder
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [((8+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);
  import sfd_pkg::*;

  logic [LENGTH_BITS-1:0] out_len;
  logic [ByteWidth-1:0]   out_byte;

  assign out_len  = m_axis_tdata_o[ByteWidth +: LENGTH_BITS];
  assign out_byte = m_axis_tdata_o[ByteWidth-1:0];

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed under stall");

  // frame close carries a zero data byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> out_byte == '0)
    else $error("frame close with nonzero data byte");

  // a kept data byte always counts itself
  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> out_len != '0)
    else $error("data beat with zero running length");

  // input backpressure only with a result waiting at the output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

bind slip_frame_decoder sfd_checker #(
  .LENGTH_BITS (LENGTH_BITS)
) u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> sim/slip_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_checker: decoded-beat predictor and scoreboard
// Watches the byte input, the config write and the result channel of the SLIP
// frame decoder, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module slip_frame_checker #(
  parameter int unsigned LengthBits = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  input  logic                                  s_axis_tready_i,
  input  logic [7:0]                            s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                                  m_axis_tvalid_i,
  input  logic                                  m_axis_tready_i,
  // [7:0] out_byte, [LengthBits+7:8] frame_length, zero pad above
  input  logic [((8+LengthBits+7)/8)*8-1:0]     m_axis_tdata_i,
  input  logic                                  m_axis_tlast_i,   // frame_end
  input  logic                                  cfg_we_i,
  input  logic [sfd_pkg::CfgWidth-1:0]          cfg_wdata_i,      // max_length
  output int                                    mismatch_cnt_o,
  output int                                    pending_o
);
  import sfd_pkg::*;

  localparam int unsigned TdataWidth = ((8 + LengthBits + 7) / 8) * 8;
  localparam int unsigned MaxReports = 100;

  typedef enum logic [1:0] {
    ModeHunt    = 2'd0,
    ModeFrame   = 2'd1,
    ModeEscaped = 2'd2
  } rx_mode_e;

  typedef struct packed {
    logic [7:0]            data;
    logic                  frame_end;
    logic [LengthBits-1:0] length;
  } slip_result_t;

  rx_mode_e              rx_mode;
  logic [LengthBits-1:0] kept_count;
  logic [LengthBits-1:0] max_len;
  slip_result_t          expected_beats[$];
  int                    mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("%0t ns: decoder mismatch: %s", $time, msg);
    end
  endtask

  // data byte kept only while the frame is below max_len
  function automatic bit keep_byte(input logic [7:0] b, output slip_result_t res);
    res = '0;
    if (kept_count >= max_len) begin
      return 1'b0;
    end
    kept_count = kept_count + LengthBits'(1);
    res.data   = b;
    res.length = kept_count;
    return 1'b1;
  endfunction

  function automatic bit decode_rx_byte(input logic [7:0] rx, output slip_result_t res);
    logic [7:0] b;
    b   = rx;
    res = '0;
    case (rx_mode)
      ModeFrame: begin
        if (b == SlipEnd) begin
          res.frame_end = 1'b1;
          res.length    = kept_count;
          rx_mode       = ModeHunt;
          kept_count    = '0;
          return 1'b1;
        end
        if (b == SlipEsc) begin
          rx_mode = ModeEscaped;
          return 1'b0;
        end
        return keep_byte(b, res);
      end
      ModeEscaped: begin
        rx_mode = ModeFrame;
        if (b == SlipEscEnd) begin
          b = SlipEnd;
        end else if (b == SlipEscEsc) begin
          b = SlipEsc;
        end
        return keep_byte(b, res);
      end
      default: begin
        if (b == SlipEnd) begin
          rx_mode    = ModeFrame;
          kept_count = '0;
        end else begin
          rx_mode = ModeHunt;
        end
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    slip_result_t res;
    slip_result_t want;
    if (!rst_ni) begin
      rx_mode    = ModeHunt;
      kept_count = '0;
      max_len    = '1;
      expected_beats.delete();
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (decode_rx_byte(s_axis_tdata_i, res)) begin
          expected_beats.push_back(res);
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b",
                                    m_axis_tdata_i, m_axis_tlast_i));
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tdata_i[7:0] !== want.data) begin
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      m_axis_tdata_i[7:0], want.data));
          end
          if (m_axis_tlast_i !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      m_axis_tlast_i, want.frame_end));
          end
          if (m_axis_tdata_i[8 +: LengthBits] !== want.length) begin
            report_mismatch($sformatf("frame_length %0d, expected %0d",
                                      m_axis_tdata_i[8 +: LengthBits], want.length));
          end
          if (m_axis_tdata_i[TdataWidth-1:8+LengthBits] !== '0) begin
            report_mismatch($sformatf("nonzero pad bits in tdata %h", m_axis_tdata_i));
          end
        end
      end
      if (cfg_we_i) begin
        max_len = cfg_wdata_i[LengthBits-1:0];
      end
      pending_o <= expected_beats.size();
    end
  end

endmodule

>>> sim/slip_frame_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_decoder_test: stimulus and verdict for the SLIP frame decoder
// Drives directed and random framed byte streams under several max_length
// settings with random idling on both sides; the checker scores the results.
// ----------------------------------------------------------------------------
module slip_frame_decoder_test;
  import sfd_pkg::*;

  localparam int unsigned LengthBits  = 12;
  localparam int unsigned TdataWidth  = ((8 + LengthBits + 7) / 8) * 8;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseBytes  = 270;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned Limit       = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [7:0]            s_data = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [TdataWidth-1:0] m_data;
  logic                  m_last;
  logic                  cfg_we = 1'b0;
  logic [CfgWidth-1:0]   cfg_wdata = '0;
  int                    mismatch_cnt;
  int                    pending;

  bit                    idle_on = 1'b1;
  bit                    hold_req = 1'b0;
  int unsigned           cur_max_len = (1 << LengthBits) - 1;
  int unsigned           cycle_cnt = 0;
  logic [7:0]            stream_q[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  slip_frame_decoder #(
    .LENGTH_BITS(LengthBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  slip_frame_checker #(
    .LengthBits(LengthBits)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= Limit) begin
      $display("slip_frame_decoder_test NOT OK");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < HoldCycles; i++) begin
          m_ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 9) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) begin
      send_byte(stream_q.pop_front());
    end
  endtask

  // wait until every expected beat is out and the pipeline is quiet
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_length(input int unsigned v);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v[CfgWidth-1:0];
    cur_max_len = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // well-formed frame: END, n escaped-as-needed data bytes, END
  task automatic push_frame(input int unsigned n);
    logic [7:0] b;
    int unsigned r;
    stream_q.push_back(SlipEnd);
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      b = 8'($urandom_range(255));
      if (r < 10) begin
        stream_q.push_back(SlipEsc);
        stream_q.push_back(SlipEscEnd);
      end else if (r < 20) begin
        stream_q.push_back(SlipEsc);
        stream_q.push_back(SlipEscEsc);
      end else if (r < 24) begin
        // escape followed by an arbitrary byte, END included
        stream_q.push_back(SlipEsc);
        stream_q.push_back(b);
      end else if (b == SlipEnd) begin
        stream_q.push_back(SlipEsc);
        stream_q.push_back(SlipEscEnd);
      end else if (b == SlipEsc) begin
        stream_q.push_back(SlipEsc);
        stream_q.push_back(SlipEscEsc);
      end else begin
        stream_q.push_back(b);
      end
    end
    stream_q.push_back(SlipEnd);
  endtask

  task automatic build_random(input int unsigned target);
    int unsigned r;
    int unsigned n;
    int unsigned top_len;
    while (stream_q.size() < target) begin
      r = $urandom_range(99);
      if (r < 72) begin
        top_len = (cur_max_len > 36) ? 40 : cur_max_len + 4;
        if ($urandom_range(7) == 0) n = $urandom_range(0, top_len);
        else n = $urandom_range(0, 12);
        push_frame(n);
      end else if (r < 82) begin
        n = $urandom_range(1, 5);
        repeat (n) stream_q.push_back(8'($urandom_range(255)));
      end else if (r < 90) begin
        stream_q.push_back(SlipEnd);
        stream_q.push_back(SlipEnd);
      end else begin
        // opened frame with raw random content and no close of its own
        stream_q.push_back(SlipEnd);
        n = $urandom_range(1, 8);
        repeat (n) stream_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int unsigned phase_max[NumPhases];
    phase_max[0] = 1;
    phase_max[1] = 0;
    phase_max[2] = (1 << LengthBits) - 1;
    phase_max[3] = $urandom_range(2, 8);
    phase_max[4] = $urandom_range(1, (1 << LengthBits) - 1);
    phase_max[5] = $urandom_range(9, 30);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: noise while hunting, all escape forms, END after ESC, empty frame
    stream_q = '{8'h00, 8'hFF, SlipEsc, SlipEscEnd, SlipEnd,
                 8'h00, 8'hFF, SlipEsc, SlipEscEnd, SlipEsc, SlipEscEsc,
                 SlipEsc, SlipEnd, SlipEsc, 8'h41, SlipEnd,
                 SlipEnd, SlipEnd};
    send_stream();

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_max_length(phase_max[p]);
      idle_on  = (p != 4);
      hold_req = (p == 2);
      build_random(PhaseBytes);
      send_stream();
    end
    idle_on = 1'b1;
    settle();

    if (mismatch_cnt == 0) begin
      $display("slip_frame_decoder_test OK");
    end else begin
      $display("slip_frame_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
